>>> rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define DPB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high
`define DPB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked through reset as well
`define DPB_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/dpb_pkg.sv
// Types, register codes and reset values of the depth pixel back-projection core
package dpb_pkg;

   localparam int unsigned PixWidth    = 12;
   localparam int unsigned DepthWidth  = 16;
   localparam int unsigned CenterWidth = 16;
   localparam int unsigned InvWidth    = 24;
   localparam int unsigned CoordWidth  = 32;
   localparam int unsigned ColorWidth  = 24;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrWidth    = 24;
   localparam int unsigned FracShift   = 28;

   localparam logic [CsrIdxWidth-1:0] REG_INV_FOCAL       = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_CENTER_X        = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_CENTER_Y        = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_SPLIT_ROW       = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_FAR_LIMIT_UPPER = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_FAR_LIMIT_LOWER = 3'd5;
   localparam logic [CsrIdxWidth-1:0] REG_NEAR_LIMIT      = 3'd6;

   localparam logic [InvWidth-1:0]    RST_INV_FOCAL       = 24'd23967;
   localparam logic [CenterWidth-1:0] RST_CENTER_X        = 16'd5120;
   localparam logic [CenterWidth-1:0] RST_CENTER_Y        = 16'd3840;
   localparam logic [PixWidth-1:0]    RST_SPLIT_ROW       = 12'd100;
   localparam logic [DepthWidth-1:0]  RST_FAR_LIMIT_UPPER = 16'd6000;
   localparam logic [DepthWidth-1:0]  RST_FAR_LIMIT_LOWER = 16'd3000;
   localparam logic [DepthWidth-1:0]  RST_NEAR_LIMIT      = 16'd1;

   typedef struct packed {
      logic [PixWidth-1:0]   pixel_col;
      logic [PixWidth-1:0]   pixel_row;
      logic [DepthWidth-1:0] depth_mm;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
   } req_word_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
      logic [DepthWidth-1:0]        point_z;
      logic [ColorWidth-1:0]        packed_color;
   } rsp_word_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_adv_type;

endpackage

>>> rtl/depth_pixel_backprojection_core.sv
// Depth pixel back-projection: one pixel word a clock in, one 3D point word out for
// each kept pixel. Pixels with depth outside the near and far limits are dropped at
// entry. Sustained rate is one word per cycle while no stall holds it; a word passes
// the offset stage, the two registered multiplies (offset by 1/f, then by depth)
// and the output register. A stall on the result side holds the pipeline stage by
// stage, so empty stages keep filling while the output word waits.
module depth_pixel_backprojection_core
   import dpb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]    csr_wdata
);

   logic [InvWidth-1:0]    inv_focal_ff;
   logic [CenterWidth-1:0] center_x_ff, center_y_ff;
   logic [PixWidth-1:0]    split_row_ff;
   logic [DepthWidth-1:0]  far_upper_ff, far_lower_ff, near_limit_ff;

   logic [4:1]             valid_ff;
   logic [4:1]             valid_in;
   logic [4:1]             stage_ready;
   stage_adv_type          adv;

   logic [DepthWidth-1:0]  far_limit;
   logic                   keep;

   logic [DepthWidth-1:0]  depth1_ff, depth2_ff, depth3_ff, depth4_ff;
   logic [ColorWidth-1:0]  color1_ff, color2_ff, color3_ff, color4_ff;
   logic signed [CoordWidth-1:0] point_x, point_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_focal_ff  <= RST_INV_FOCAL;
         center_x_ff   <= RST_CENTER_X;
         center_y_ff   <= RST_CENTER_Y;
         split_row_ff  <= RST_SPLIT_ROW;
         far_upper_ff  <= RST_FAR_LIMIT_UPPER;
         far_lower_ff  <= RST_FAR_LIMIT_LOWER;
         near_limit_ff <= RST_NEAR_LIMIT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_INV_FOCAL:       inv_focal_ff  <= csr_wdata;
            REG_CENTER_X:        center_x_ff   <= csr_wdata[CenterWidth-1:0];
            REG_CENTER_Y:        center_y_ff   <= csr_wdata[CenterWidth-1:0];
            REG_SPLIT_ROW:       split_row_ff  <= csr_wdata[PixWidth-1:0];
            REG_FAR_LIMIT_UPPER: far_upper_ff  <= csr_wdata[DepthWidth-1:0];
            REG_FAR_LIMIT_LOWER: far_lower_ff  <= csr_wdata[DepthWidth-1:0];
            REG_NEAR_LIMIT:      near_limit_ff <= csr_wdata[DepthWidth-1:0];
            default: ;
         endcase
      end
   end

   // drop out-of-range depths at entry
   always_comb begin
      far_limit = (req_word.pixel_row > split_row_ff) ? far_lower_ff : far_upper_ff;
      keep      = (req_word.depth_mm >= near_limit_ff) && (req_word.depth_mm <= far_limit);
   end

   always_comb begin
      stage_ready[4] = !valid_ff[4] || !rsp_stall;
      stage_ready[3] = !valid_ff[3] || stage_ready[4];
      stage_ready[2] = !valid_ff[2] || stage_ready[3];
      stage_ready[1] = !valid_ff[1] || stage_ready[2];
      adv.s1 = stage_ready[1];
      adv.s2 = stage_ready[2];
      adv.s3 = stage_ready[3];
      adv.s4 = stage_ready[4];
      valid_in[1] = adv.s1 ? (req_valid && keep) : valid_ff[1];
      valid_in[2] = adv.s2 ? valid_ff[1] : valid_ff[2];
      valid_in[3] = adv.s3 ? valid_ff[2] : valid_ff[3];
      valid_in[4] = adv.s4 ? valid_ff[3] : valid_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         depth1_ff <= req_word.depth_mm;
         color1_ff <= {req_word.red, req_word.green, req_word.blue};
      end
      if (adv.s2) begin
         depth2_ff <= depth1_ff;
         color2_ff <= color1_ff;
      end
      if (adv.s3) begin
         depth3_ff <= depth2_ff;
         color3_ff <= color2_ff;
      end
      if (adv.s4) begin
         depth4_ff <= depth3_ff;
         color4_ff <= color3_ff;
      end
   end

   dpb_axis u_axis_x (
      .clock     (clock),
      .adv       (adv),
      .pixel     (req_word.pixel_col),
      .center    (center_x_ff),
      .inv_focal (inv_focal_ff),
      .depth_s2  (depth2_ff),
      .coord     (point_x)
   );

   dpb_axis u_axis_y (
      .clock     (clock),
      .adv       (adv),
      .pixel     (req_word.pixel_row),
      .center    (center_y_ff),
      .inv_focal (inv_focal_ff),
      .depth_s2  (depth2_ff),
      .coord     (point_y)
   );

   assign req_stall = !stage_ready[1];
   assign rsp_valid = valid_ff[4];

   always_comb begin
      rsp_word.point_x      = point_x;
      rsp_word.point_y      = point_y;
      rsp_word.point_z      = depth4_ff;
      rsp_word.packed_color = color4_ff;
   end

endmodule

>>> rtl/dpb_axis.sv
// One axis of the projection: offset, two registered multiplies, scale and sign
module dpb_axis
   import dpb_pkg::*;
(
   input  logic                         clock,
   input  stage_adv_type                adv,
   input  logic [PixWidth-1:0]          pixel,
   input  logic [CenterWidth-1:0]       center,
   input  logic [InvWidth-1:0]          inv_focal,
   input  logic [DepthWidth-1:0]        depth_s2,
   output logic signed [CoordWidth-1:0] coord
);

   localparam int unsigned OffWidth   = CenterWidth + 1;
   localparam int unsigned Prod1Width = CenterWidth + InvWidth;
   localparam int unsigned Prod2Width = Prod1Width + DepthWidth;
   localparam int unsigned QWidth     = Prod2Width - FracShift;

   logic [OffWidth-1:0]    offset;
   logic [CenterWidth-1:0] mag_in;
   logic [CenterWidth-1:0] mag_ff;
   logic                   neg1_ff, neg2_ff, neg3_ff;
   logic [Prod1Width-1:0]  prod1_in, prod1_ff;
   logic [Prod2Width-1:0]  prod2_in, prod2_ff;
   logic [CoordWidth-1:0]  quot;
   logic [CoordWidth-1:0]  coord_in, coord_ff;

   always_comb begin
      offset   = {1'b0, pixel, 4'b0000} - {1'b0, center};
      mag_in   = offset[OffWidth-1] ? CenterWidth'(~offset + 1'b1)
                                    : offset[CenterWidth-1:0];
      prod1_in = Prod1Width'(mag_ff) * Prod1Width'(inv_focal);
      prod2_in = Prod2Width'(prod1_ff) * Prod2Width'(depth_s2);
      quot     = CoordWidth'(prod2_ff[Prod2Width-1 -: QWidth]);
      coord_in = neg3_ff ? (~quot + 1'b1) : quot;
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         mag_ff  <= mag_in;
         neg1_ff <= offset[OffWidth-1];
      end
      if (adv.s2) begin
         prod1_ff <= prod1_in;
         neg2_ff  <= neg1_ff;
      end
      if (adv.s3) begin
         prod2_ff <= prod2_in;
         neg3_ff  <= neg2_ff;
      end
      if (adv.s4) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

>>> rtl/dpb_checker.sv
// Port-level checks of the back-projection core and their bind
`include "assert_macros.svh"

module dpb_checker
   import dpb_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   `DPB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   `DPB_ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)
   `DPB_ASSERT_IMP(a_no_stall_through, clock, reset, !rsp_stall, !req_stall)

endmodule

bind depth_pixel_backprojection_core dpb_checker u_dpb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

>>> verif/tb.sv
// Testbench for the depth pixel back-projection core: directed and random pixels, scoreboard
`timescale 1ns / 100ps

module tb;
   import dpb_pkg::*;

   localparam logic [CsrIdxWidth-1:0] REG_UNUSED = 3'd7;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned RandomPhases = 8;
   localparam int unsigned PixelsPerPhase = 250;

   typedef struct {
      logic [InvWidth-1:0]    inv_focal;
      logic [CenterWidth-1:0] center_x;
      logic [CenterWidth-1:0] center_y;
      logic [PixWidth-1:0]    split_row;
      logic [DepthWidth-1:0]  far_upper;
      logic [DepthWidth-1:0]  far_lower;
      logic [DepthWidth-1:0]  near;
   } camera_cfg_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrWidth-1:0]    csr_wdata = '0;

   camera_cfg_type cam = '{RST_INV_FOCAL, RST_CENTER_X, RST_CENTER_Y, RST_SPLIT_ROW,
                           RST_FAR_LIMIT_UPPER, RST_FAR_LIMIT_LOWER, RST_NEAR_LIMIT};
   rsp_word_type   pending_points [$];
   rsp_word_type   new_point;
   rsp_word_type   want_point;

   int  pixels_sent = 0;
   int  pixels_dropped = 0;
   int  points_seen = 0;
   int  mismatch_count = 0;
   int  settings_loaded = 0;
   int  burst_left = 0;
   int  stall_hold = 0;
   bit  bursty = 1'b1;
   bit  stall_on = 1'b1;

   depth_pixel_backprojection_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // (16*pix - centre) * inv_focal * depth / 2^28, toward zero, saturated
   function automatic logic [CoordWidth-1:0] axis_mm(input logic [PixWidth-1:0] pix,
                                                     input logic [CenterWidth-1:0] centre,
                                                     input logic [DepthWidth-1:0] depth);
      longint          offset;
      longint unsigned mag;
      longint unsigned q;
      offset = 16 * longint'(pix) - longint'(centre);
      mag = (offset < 0) ? -offset : offset;
      q = (mag * cam.inv_focal * depth) >> FracShift;
      if (offset < 0) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         q = -q;
      end else if (q > 64'h7FFF_FFFF) begin
         q = 64'h7FFF_FFFF;
      end
      return q[CoordWidth-1:0];
   endfunction

   function automatic bit backproject(input req_word_type w, output rsp_word_type p);
      logic [DepthWidth-1:0] far;
      far = (w.pixel_row > cam.split_row) ? cam.far_lower : cam.far_upper;
      p = '0;
      if (w.depth_mm < cam.near || w.depth_mm > far) return 1'b0;
      p.point_x = axis_mm(w.pixel_col, cam.center_x, w.depth_mm);
      p.point_y = axis_mm(w.pixel_row, cam.center_y, w.depth_mm);
      p.point_z = w.depth_mm;
      p.packed_color = {w.red, w.green, w.blue};
      return 1'b1;
   endfunction

   function automatic req_word_type make_pixel(input int col, input int row, input int depth,
                                               input int rgb);
      req_word_type w;
      w.pixel_col = PixWidth'(col);
      w.pixel_row = PixWidth'(row);
      w.depth_mm = DepthWidth'(depth);
      {w.red, w.green, w.blue} = ColorWidth'(rgb);
      return w;
   endfunction

   function automatic req_word_type random_pixel();
      req_word_type          w;
      logic [DepthWidth-1:0] far;
      w.pixel_col = PixWidth'($urandom_range(0, 4095));
      w.pixel_row = PixWidth'($urandom_range(0, 4095));
      {w.red, w.green, w.blue} = ColorWidth'($urandom);
      far = (w.pixel_row > cam.split_row) ? cam.far_lower : cam.far_upper;
      if (cam.near <= far && $urandom_range(0, 4) != 0)
         w.depth_mm = DepthWidth'($urandom_range(far, cam.near));
      else w.depth_mm = DepthWidth'($urandom);
      return w;
   endfunction

   function automatic camera_cfg_type random_cfg();
      camera_cfg_type c;
      case ($urandom_range(0, 4))
         0: c.inv_focal = InvWidth'(1);
         1: c.inv_focal = '1;
         2: c.inv_focal = InvWidth'($urandom_range(1, 24'hFFFFFF));
         default: c.inv_focal = InvWidth'((1 << 24) / $urandom_range(100, 3000));
      endcase
      c.center_x = CenterWidth'($urandom);
      c.center_y = CenterWidth'($urandom);
      c.split_row = PixWidth'($urandom);
      c.far_upper = DepthWidth'($urandom);
      c.far_lower = DepthWidth'($urandom);
      c.near = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      return c;
   endfunction

   task automatic note_mismatch(input string field, input logic [CoordWidth-1:0] want,
                                input logic [CoordWidth-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("tb: %s mismatch on point %0d: expected %h, got %h",
                  field, points_seen, want, got);
   endtask

   // receiver stall pattern: random levels held for random spans
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         stall_hold <= $urandom_range(0, 7);
         rsp_stall <= stall_on && ($urandom_range(0, 2) == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pixels_sent++;
         if (backproject(req_word, new_point))
            pending_points.insert(pending_points.size(), new_point);
         else pixels_dropped++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         points_seen++;
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("tb: unexpected point word %h", rsp_word);
         end else begin
            want_point = pending_points.pop_front();
            if (rsp_word.point_x !== want_point.point_x)
               note_mismatch("point_x", want_point.point_x, rsp_word.point_x);
            if (rsp_word.point_y !== want_point.point_y)
               note_mismatch("point_y", want_point.point_y, rsp_word.point_y);
            if (rsp_word.point_z !== want_point.point_z)
               note_mismatch("point_z", CoordWidth'(want_point.point_z),
                             CoordWidth'(rsp_word.point_z));
            if (rsp_word.packed_color !== want_point.packed_color)
               note_mismatch("packed_color", CoordWidth'(want_point.packed_color),
                             CoordWidth'(rsp_word.packed_color));
         end
      end
   end

   task automatic send_pixel(input req_word_type w);
      if (bursty && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic load_settings(input camera_cfg_type c);
      logic [CsrWidth-1:0]    vals [7];
      logic [CsrIdxWidth-1:0] regs [7];
      settle();
      regs = '{REG_INV_FOCAL, REG_CENTER_X, REG_CENTER_Y, REG_SPLIT_ROW,
               REG_FAR_LIMIT_UPPER, REG_FAR_LIMIT_LOWER, REG_NEAR_LIMIT};
      vals = '{c.inv_focal, CsrWidth'(c.center_x), CsrWidth'(c.center_y),
               CsrWidth'(c.split_row), CsrWidth'(c.far_upper), CsrWidth'(c.far_lower),
               CsrWidth'(c.near)};
      for (int i = 0; i < 7; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cam = c;
      settings_loaded++;
   endtask

   task automatic test_reset_settings();
      send_pixel(make_pixel(320, 240, 1000, 24'h804020));
      send_pixel(make_pixel(0, 0, 6000, 24'hFFFFFF));
      send_pixel(make_pixel(4095, 100, 6000, 24'h000000));
      send_pixel(make_pixel(4095, 101, 3000, 24'hAA55AA));
      send_pixel(make_pixel(0, 101, 3001, 24'h123456));
      send_pixel(make_pixel(10, 50, 6001, 24'h654321));
      send_pixel(make_pixel(10, 50, 0, 24'h0F0F0F));
      send_pixel(make_pixel(4095, 4095, 1, 24'h55AA55));
      send_pixel(make_pixel(0, 4095, 3000, 24'hF0F0F0));
   endtask

   task automatic test_extreme_settings();
      load_settings('{24'hFFFFFF, 16'd0, 16'hFFFF, 12'd4095, 16'hFFFF, 16'hFFFF, 16'd0});
      send_pixel(make_pixel(4095, 0, 65535, 24'hFFFFFF));
      send_pixel(make_pixel(0, 4095, 65535, 24'h000000));
      send_pixel(make_pixel(0, 0, 0, 24'h010203));
      send_pixel(make_pixel(2048, 2048, 32768, 24'h7F7F7F));
      // out-of-range register index must leave the settings alone
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= REG_UNUSED;
      csr_wdata <= '1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      send_pixel(make_pixel(4095, 4095, 65535, 24'h808080));
      // zero reciprocal, crossed limits on the upper rows
      load_settings('{24'd0, 16'hFFFF, 16'd0, 12'd0, 16'd0, 16'hFFFF, 16'hFFFF});
      send_pixel(make_pixel(5, 0, 65535, 24'h112233));
      send_pixel(make_pixel(5, 0, 0, 24'h445566));
      send_pixel(make_pixel(4095, 1, 65535, 24'h778899));
      send_pixel(make_pixel(0, 4095, 65534, 24'hAABBCC));
      // crossed limits on the lower rows only
      load_settings('{24'd1, 16'd1000, 16'd2000, 12'd2000, 16'd1000, 16'd100, 16'd500});
      send_pixel(make_pixel(100, 2001, 300, 24'hDDEEFF));
      send_pixel(make_pixel(100, 1999, 500, 24'h102030));
      send_pixel(make_pixel(100, 2000, 1000, 24'h405060));
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < RandomPhases; ph++) begin
         bursty = (ph % 3 != 0);
         stall_on = (ph % 4 != 1);
         load_settings(random_cfg());
         repeat (PixelsPerPhase) send_pixel(random_pixel());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_extreme_settings();
      test_random_phases();
      settle();
      $display("tb: %0d pixels sent, %0d dropped at the limits, %0d points checked",
               pixels_sent, pixels_dropped, points_seen);
      $display("tb: %0d register settings loaded, %0d mismatches", settings_loaded,
               mismatch_count);
      if (mismatch_count == 0 && pending_points.size() == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb: timeout");
      $display("tb: errors");
      $finish;
   end

endmodule
